FILE: sv/bfs_pkg.sv
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int KIND_W = 2;
  localparam int ITEM_W = 16;
  localparam int CAP_W  = 5;
  localparam int FILL_W = 5;
  localparam int STEP_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [KIND_W-1:0] K_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] K_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] K_FIND = 2'd2;
  localparam logic [KIND_W-1:0] K_PEEK = 2'd3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_ENQ      = 4'd1;
  localparam step_t S_DEQ_RD   = 4'd2;
  localparam step_t S_DEQ_POP  = 4'd3;
  localparam step_t S_PK_RD    = 4'd4;
  localparam step_t S_PK_FIRST = 4'd5;
  localparam step_t S_PK_LAST  = 4'd6;
  localparam step_t S_FD_FIRST = 4'd7;
  localparam step_t S_FD_LOOP  = 4'd8;
  localparam step_t S_EMIT     = 4'd9;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_DISPATCH = 3'd2,
    J_IF_EMPTY = 3'd3,
    J_SCAN     = 3'd4,
    J_WAIT_OUT = 3'd5
  } jump_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_LAST = 2'd1,
    RD_SCAN = 2'd2
  } rd_sel_t;

  typedef struct packed {
    jump_t   jmp;
    step_t   target;
    rd_sel_t rd_sel;
    logic    take;
    logic    enq;
    logic    pop;
    logic    lat_first;
    logic    lat_last;
    logic    scan_first;
    logic    scan_adv;
    logic    cmp;
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic              in_valid;
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              scan_done;
    logic              out_free;
  } stat_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{jmp: J_NEXT, target: S_IDLE, rd_sel: RD_HEAD, default: 1'b0};
    unique case (s)
      S_IDLE: begin
        c.take = 1'b1;
        c.jmp  = J_DISPATCH;
      end
      S_ENQ: begin
        c.enq    = 1'b1;
        c.jmp    = J_GOTO;
        c.target = S_EMIT;
      end
      S_DEQ_RD: begin
        c.jmp    = J_IF_EMPTY;
        c.target = S_EMIT;
      end
      S_DEQ_POP: begin
        c.pop    = 1'b1;
        c.jmp    = J_GOTO;
        c.target = S_EMIT;
      end
      S_PK_RD: begin
        c.jmp    = J_IF_EMPTY;
        c.target = S_EMIT;
      end
      S_PK_FIRST: begin
        c.lat_first = 1'b1;
        c.rd_sel    = RD_LAST;
      end
      S_PK_LAST: begin
        c.lat_last = 1'b1;
        c.jmp      = J_GOTO;
        c.target   = S_EMIT;
      end
      S_FD_FIRST: begin
        c.scan_first = 1'b1;
        c.jmp        = J_IF_EMPTY;
        c.target     = S_EMIT;
      end
      S_FD_LOOP: begin
        c.cmp      = 1'b1;
        c.scan_adv = 1'b1;
        c.rd_sel   = RD_SCAN;
        c.jmp      = J_SCAN;
        c.target   = S_EMIT;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.jmp    = J_WAIT_OUT;
        c.target = S_IDLE;
      end
      default: begin
        c.jmp    = J_GOTO;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic step_t entry_of(input logic [KIND_W-1:0] k);
    step_t s;
    unique case (k)
      K_ENQ:   s = S_ENQ;
      K_DEQ:   s = S_DEQ_RD;
      K_FIND:  s = S_FD_FIRST;
      K_PEEK:  s = S_PK_RD;
      default: s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/bfs_cfg_if.sv
`timescale 1ns / 1ps

interface bfs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bfs_pkg::CAP_W-1:0]  capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink (input valid, capacity_limit, output ready);
endinterface

FILE: sv/bfs_req_if.sv
`timescale 1ns / 1ps

interface bfs_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfs_pkg::KIND_W-1:0]  kind;
  logic [bfs_pkg::ITEM_W-1:0]  item;

  modport source (output valid, kind, item, input ready);
  modport sink (input valid, kind, item, output ready);
endinterface

FILE: sv/bfs_res_if.sv
`timescale 1ns / 1ps

interface bfs_res_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bfs_pkg::ITEM_W-1:0]  item_out;
  logic [bfs_pkg::ITEM_W-1:0]  last_item;
  logic                        empty_res;
  logic [bfs_pkg::FILL_W-1:0]  fill_level;

  modport source (output valid, ok, item_out, last_item, empty_res, fill_level, input ready);
  modport sink (input valid, ok, item_out, last_item, empty_res, fill_level, output ready);
endinterface

FILE: sv/bfs_ram.sv
`timescale 1ns / 1ps

module bfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bfs_useq.sv
`timescale 1ns / 1ps

module bfs_useq (
  input  logic           clk,
  input  logic           rst,
  input  bfs_pkg::stat_t stat,
  output bfs_pkg::ctrl_t ctrl
);
  import bfs_pkg::*;

  step_t step;
  step_t step_next;

  assign ctrl = ucode(step);

  always_comb begin
    step_next = step + 4'd1;
    unique case (ctrl.jmp)
      J_NEXT:     step_next = step + 4'd1;
      J_GOTO:     step_next = ctrl.target;
      J_DISPATCH: step_next = stat.in_valid ? entry_of(stat.kind) : step;
      J_IF_EMPTY: step_next = stat.empty ? ctrl.target : step + 4'd1;
      J_SCAN:     step_next = stat.scan_done ? ctrl.target : step;
      J_WAIT_OUT: step_next = stat.out_free ? ctrl.target : step;
      default:    step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: sv/bfs_dp.sv
`timescale 1ns / 1ps

module bfs_dp #(
  parameter int DEPTH = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  bfs_pkg::ctrl_t ctrl,
  output bfs_pkg::stat_t stat,
  bfs_cfg_if.sink        cfg,
  bfs_req_if.sink        req,
  bfs_res_if.source      res
);
  import bfs_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int SW   = (HANDLE_WIDTH < ITEM_W) ? HANDLE_WIDTH : ITEM_W;
  localparam int KW   = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [AW-1:0] wrap(input logic [SUMW-1:0] s);
    logic [SUMW-1:0] d;
    d = s - SUMW'(DEPTH);
    return (s >= SUMW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  logic [CAP_W-1:0]  cap;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [AW-1:0]     sptr;
  logic [SW-1:0]     key;
  logic [SW-1:0]     first;
  logic [SW-1:0]     last;
  logic              ok;
  logic              out_valid;
  logic              out_ok;
  logic [ITEM_W-1:0] out_item;
  logic [ITEM_W-1:0] out_last;
  logic              out_empty;
  logic [FILL_W-1:0] out_fill;

  logic              accept;
  logic              not_full;
  logic              do_enq;
  logic              match;
  logic              out_free;
  logic [AW-1:0]     tail_slot;
  logic [AW-1:0]     last_slot;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     sptr_inc;
  logic [AW-1:0]     raddr;
  logic [SW-1:0]     rdata;

  assign accept    = ctrl.take && req.valid;
  assign not_full  = (KW'(count) < KW'(cap)) && (count < CW'(DEPTH));
  assign do_enq    = ctrl.enq && not_full;
  assign match     = (rdata == key);
  assign out_free  = !out_valid || res.ready;
  assign tail_slot = wrap(SUMW'(head) + SUMW'(count));
  assign last_slot = wrap(SUMW'(head) + SUMW'(count) - SUMW'(1));
  assign head_inc  = wrap(SUMW'(head) + SUMW'(1));
  assign sptr_inc  = wrap(SUMW'(sptr) + SUMW'(1));

  always_comb begin
    case (ctrl.rd_sel)
      RD_HEAD: raddr = head;
      RD_LAST: raddr = last_slot;
      RD_SCAN: raddr = sptr;
      default: raddr = head;
    endcase
  end

  bfs_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_enq),
    .waddr(tail_slot),
    .wdata(key),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign stat.in_valid  = req.valid;
  assign stat.kind      = req.kind;
  assign stat.empty     = (count == '0);
  assign stat.scan_done = match || (idx == count);
  assign stat.out_free  = out_free;

  assign cfg.ready      = !rst;
  assign req.ready      = ctrl.take && !rst;
  assign res.valid      = out_valid;
  assign res.ok         = out_ok;
  assign res.item_out   = out_item;
  assign res.last_item  = out_last;
  assign res.empty_res  = out_empty;
  assign res.fill_level = out_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        cap <= cfg.capacity_limit;
      end
      if (do_enq) begin
        count <= count + CW'(1);
      end
      if (ctrl.pop) begin
        head  <= head_inc;
        count <= count - CW'(1);
      end
      if (ctrl.emit && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok    <= 1'b0;
      first <= '0;
      last  <= '0;
      key   <= req.item[SW-1:0];
    end
    if (do_enq) begin
      ok <= 1'b1;
    end
    if (ctrl.pop) begin
      first <= rdata;
      ok    <= 1'b1;
    end
    if (ctrl.lat_first) begin
      first <= rdata;
    end
    if (ctrl.lat_last) begin
      last <= rdata;
      ok   <= 1'b1;
    end
    if (ctrl.scan_first) begin
      sptr <= head_inc;
      idx  <= CW'(1);
    end
    if (ctrl.scan_adv && (idx < count)) begin
      sptr <= sptr_inc;
      idx  <= idx + CW'(1);
    end
    if (ctrl.cmp && match) begin
      ok <= 1'b1;
    end
    if (ctrl.emit && out_free) begin
      out_ok    <= ok;
      out_item  <= ITEM_W'(first);
      out_last  <= ITEM_W'(last);
      out_empty <= (count == '0);
      out_fill  <= FILL_W'(count);
    end
  end

endmodule

FILE: sv/bounded_fifo_with_search.sv
// Each request runs as a sequence of steps: enqueue writes the item at the tail; dequeue
// reads and pops the head; peek reads the head, then the last entry; contains compares
// one stored entry per cycle, stopping on a hit or after the last entry. On an empty queue
// dequeue, peek and contains go straight to the result, which is registered and shown as
// the steps return to idle, the only step that takes a request; a held result stalls them.
// Reset (synchronous): queue empty, head at slot 0, capacity 16; storage is not cleared.
`timescale 1ns / 1ps

module bounded_fifo_with_search #(
  parameter int DEPTH = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  bfs_cfg_if.sink   cfg,
  bfs_req_if.sink   req,
  bfs_res_if.source res
);
  import bfs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  bfs_useq u_useq (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .ctrl(ctrl)
  );

  bfs_dp #(
    .DEPTH(DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl),
    .stat(stat),
    .cfg (cfg),
    .req (req),
    .res (res)
  );

endmodule
